### hw/rtl/c_comment_string_stripper_core_defines.svh
// assertion macros used by the stripper result queue
`ifndef C_COMMENT_STRING_STRIPPER_CORE_DEFINES_SVH
`define C_COMMENT_STRING_STRIPPER_CORE_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define CCS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ccs_pkg.sv
// shared types for the comment and literal stripper
package ccs_pkg;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } ccs_item_t;

  typedef struct packed {
    logic [1:0] n;
    ccs_item_t  item1;
    ccs_item_t  item0;
  } ccs_push_t;

endpackage

### hw/rtl/c_comment_string_stripper_core.sv
// C comment and literal stripper: one source byte per transfer in, filtered bytes out.
// Each input transfer is decoded in the cycle it is accepted by a small lexer state
// register and yields zero, one or two result transfers, which go into an output queue
// of OUT_DEPTH entries that drains one result per cycle while the sink is ready. An input
// byte is taken every cycle while the queue has at least two free entries, that is while
// no more than OUT_DEPTH - 2 results are queued. With a ready sink every byte with at most
// one result keeps the rate at one byte per cycle; a byte that yields two results (a held
// slash followed by a byte that opens no comment, or end of text after a held slash or
// inside a literal) leaves one extra result queued, and once such extra results pile up
// past OUT_DEPTH - 2 the input stalls until the queue drains back to OUT_DEPTH - 2 results.
// Each result is written into the queue memory before it reaches the output. The end-of-text
// transfer (in_tlast) flushes pending text and produces a zero byte with out_tlast set.
module c_comment_string_stripper_core #(
  parameter int OUT_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // last
);
  import ccs_pkg::*;

  ccs_push_t push;
  ccs_item_t out_item;
  logic      acc;
  logic      room;

  assign in_tready = room;
  assign acc       = in_tvalid && room;

  ccs_lexer u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_byte     (in_tdata),
    .end_of_text (in_tlast),
    .push        (push)
  );

  ccs_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (acc),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = out_item.data;
  assign out_tlast = out_item.last;

endmodule

### hw/rtl/ccs_lexer.sv
// lexer state register and per-byte decode into up to two results
module ccs_lexer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         in_byte,
  input  logic               end_of_text,
  output ccs_pkg::ccs_push_t push
);
  import ccs_pkg::*;

  localparam logic [2:0] M_NORMAL     = 3'd0;
  localparam logic [2:0] M_SLASH      = 3'd1;
  localparam logic [2:0] M_BLOCK      = 3'd2;
  localparam logic [2:0] M_BLOCK_STAR = 3'd3;
  localparam logic [2:0] M_LINE       = 3'd4;
  localparam logic [2:0] M_LIT        = 3'd5;
  localparam logic [2:0] M_LIT_ESC    = 3'd6;

  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [2:0] mode;
    logic       qs;
    logic       emit;
    logic [7:0] data;
  } norm_t;

  logic [2:0] mode_r, mode_nxt;
  logic       qs_r, qs_nxt;

  function automatic norm_t normal_fn(input logic [7:0] b, input logic qs);
    norm_t r;
    r.qs = qs;
    if (b == CH_SLASH) begin
      r.mode = M_SLASH;
      r.emit = 1'b0;
      r.data = b;
    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
      r.qs   = (b == CH_SQUOTE);
      r.mode = M_LIT;
      r.emit = 1'b1;
      r.data = CH_SPACE;
    end else begin
      r.mode = M_NORMAL;
      r.emit = 1'b1;
      r.data = b;
    end
    return r;
  endfunction

  norm_t nrm;
  assign nrm = normal_fn(in_byte, qs_r);

  always_comb begin
    mode_nxt = mode_r;
    qs_nxt   = qs_r;
    push     = '0;
    if (end_of_text) begin
      mode_nxt = M_NORMAL;
      qs_nxt   = 1'b0;
      if (mode_r == M_SLASH) begin
        push.item0 = '{last: 1'b0, data: CH_SLASH};
        push.item1 = '{last: 1'b1, data: 8'h00};
        push.n     = 2'd2;
      end else if (mode_r == M_LIT || mode_r == M_LIT_ESC) begin
        push.item0 = '{last: 1'b0, data: CH_SPACE};
        push.item1 = '{last: 1'b1, data: 8'h00};
        push.n     = 2'd2;
      end else begin
        push.item0 = '{last: 1'b1, data: 8'h00};
        push.n     = 2'd1;
      end
    end else begin
      unique case (mode_r)
        M_SLASH: begin
          if (in_byte == CH_STAR) begin
            mode_nxt = M_BLOCK;
          end else if (in_byte == CH_SLASH) begin
            mode_nxt = M_LINE;
          end else begin
            push.item0 = '{last: 1'b0, data: CH_SLASH};
            push.item1 = '{last: 1'b0, data: nrm.data};
            push.n     = nrm.emit ? 2'd2 : 2'd1;
            mode_nxt   = nrm.mode;
            qs_nxt     = nrm.qs;
          end
        end
        M_BLOCK, M_BLOCK_STAR: begin
          if (mode_r == M_BLOCK_STAR && in_byte == CH_SLASH) begin
            mode_nxt = M_NORMAL;
          end else if (in_byte == CH_STAR) begin
            mode_nxt = M_BLOCK_STAR;
          end else begin
            mode_nxt = M_BLOCK;
            if (in_byte == CH_NL) begin
              push.item0 = '{last: 1'b0, data: CH_NL};
              push.n     = 2'd1;
            end
          end
        end
        M_LINE: begin
          if (in_byte == CH_NL) begin
            push.item0 = '{last: 1'b0, data: CH_NL};
            push.n     = 2'd1;
            mode_nxt   = M_NORMAL;
          end
        end
        M_LIT: begin
          if (in_byte == CH_BSLASH) begin
            mode_nxt = M_LIT_ESC;
          end else if (in_byte == (qs_r ? CH_SQUOTE : CH_DQUOTE)) begin
            push.item0 = '{last: 1'b0, data: CH_SPACE};
            push.n     = 2'd1;
            mode_nxt   = M_NORMAL;
          end else if (in_byte == CH_NL) begin
            push.item0 = '{last: 1'b0, data: CH_NL};
            push.n     = 2'd1;
          end
        end
        M_LIT_ESC: begin
          mode_nxt = M_LIT;
        end
        default: begin
          push.item0 = '{last: 1'b0, data: nrm.data};
          push.n     = nrm.emit ? 2'd1 : 2'd0;
          mode_nxt   = nrm.mode;
          qs_nxt     = nrm.qs;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      qs_r   <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      qs_r   <= qs_nxt;
    end
  end

endmodule

### hw/rtl/ccs_out_fifo.sv
// result queue taking up to two items per cycle and giving one while the reader is ready
`include "c_comment_string_stripper_core_defines.svh"

module ccs_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_en,
  input  ccs_pkg::ccs_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output ccs_pkg::ccs_item_t out_item
);
  import ccs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ccs_item_t     mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    n_push;
  logic          pop;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  assign n_push    = push_en ? push.n : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = mem_r[rp_r];
  assign room      = (cnt_r <= ROOM_MAX);
  assign wp1       = inc(wp_r);

  always_comb begin
    wp_nxt = wp_r;
    if (n_push == 2'd1) begin
      wp_nxt = wp1;
    end else if (n_push == 2'd2) begin
      wp_nxt = inc(wp1);
    end
    rp_nxt  = pop ? inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wp_r] <= push.item0;
    end
    if (n_push == 2'd2) begin
      mem_r[wp1] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `CCS_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= FULL_CNT, "fifo count above depth")
  `CCS_ASSERT_IMPL(a_empty_ptrs, cnt_r == '0, rp_r == wp_r, "empty fifo with pointers apart")
  `CCS_ASSERT_NEXT(a_pop_only, pop && n_push == 2'd0, cnt_r == $past(cnt_r) - CW'(1),
    "pop without push did not drop count")
  `CCS_ASSERT_IMPL(a_push_room, n_push != 2'd0, room, "push into fifo without room")

endmodule
